### sv/nevs_pkg.sv
// ----------------------------------------------------------------------------
// nevs_pkg
// Shared types, codes and constants of the note event window scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package nevs_pkg;

  localparam int unsigned MAX_NOTES_DEF  = 1024;
  localparam int unsigned MAX_EVENTS_DEF = 32;
  localparam logic [31:0] SPT_RESET      = 32'h0001_0000;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_ADD,
    S_CMP,
    S_ON,
    S_OFF,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] start_tick;
    logic [31:0] length_ticks;
    logic [6:0]  strength;
    logic [6:0]  pitch;
  } note_t;

  typedef struct packed {
    logic [15:0] offset;
    logic        is_on;
    logic [6:0]  pitch;
    logic [6:0]  strength;
  } event_t;

endpackage

`default_nettype wire

### sv/nevs_if.sv
// ----------------------------------------------------------------------------
// nevs_in_if / nevs_out_if
// Valid/ready channels for command items and event results.
// ----------------------------------------------------------------------------
`default_nettype none

interface nevs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] note_start_tick;
  logic [31:0] note_length_ticks;
  logic [6:0]  note_pitch;
  logic [6:0]  note_strength;
  logic [47:0] block_pos;
  logic [15:0] block_frames;

  modport source(output valid, operation, note_start_tick, note_length_ticks,
                 note_pitch, note_strength, block_pos, block_frames,
                 input ready);
  modport sink(input valid, operation, note_start_tick, note_length_ticks,
               note_pitch, note_strength, block_pos, block_frames,
               output ready);
endinterface

interface nevs_out_if;
  logic        valid;
  logic        ready;
  logic        event_valid;
  logic [15:0] event_offset;
  logic        event_is_on;
  logic [6:0]  event_pitch;
  logic [6:0]  event_strength;
  logic        event_last;

  modport source(output valid, event_valid, event_offset, event_is_on,
                 event_pitch, event_strength, event_last, input ready);
  modport sink(input valid, event_valid, event_offset, event_is_on,
               event_pitch, event_strength, event_last, output ready);
endinterface

`default_nettype wire

### sv/nevs_note_mem.sv
// ----------------------------------------------------------------------------
// nevs_note_mem
// Note table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nevs_note_mem #(
  parameter int unsigned DEPTH = nevs_pkg::MAX_NOTES_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire nevs_pkg::note_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output nevs_pkg::note_t      rdata
);

  nevs_pkg::note_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/nevs_sorter.sv
// ----------------------------------------------------------------------------
// nevs_sorter
// Row of insertion cells that keeps collected events sorted by offset.
// ----------------------------------------------------------------------------
`default_nettype none

module nevs_sorter #(
  parameter int unsigned N  = nevs_pkg::MAX_EVENTS_DEF,
  parameter int unsigned CW = $clog2(N + 1),
  parameter int unsigned IW = (N > 1) ? $clog2(N) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             clear,
  input  wire logic             ins,
  input  wire nevs_pkg::event_t key,
  input  wire logic [IW-1:0]    rd_idx,
  output nevs_pkg::event_t      rd_data,
  output logic [CW-1:0]         count
);

  nevs_pkg::event_t ev [N];
  nevs_pkg::event_t ev_next [N];
  logic [N-1:0] gt;

  // A new key lands after every entry with an equal offset, which keeps
  // the order stable.
  for (genvar i = 0; i < N; i++) begin : g_cell
    assign gt[i] = (CW'(i) < count) && (ev[i].offset > key.offset);
    if (i == 0) begin : g_first
      always_comb begin
        if (gt[i] || (CW'(i) == count)) begin
          ev_next[i] = key;
        end else begin
          ev_next[i] = ev[i];
        end
      end
    end else begin : g_rest
      always_comb begin
        if (gt[i-1]) begin
          ev_next[i] = ev[i-1];
        end else if (gt[i] || (CW'(i) == count)) begin
          ev_next[i] = key;
        end else begin
          ev_next[i] = ev[i];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (ins) begin
        ev[i] <= ev_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count <= '0;
    end else if (ins) begin
      count <= count + CW'(1);
    end
  end

  assign rd_data = ev[rd_idx];

endmodule

`default_nettype wire

### sv/note_event_window_scheduler.sv
// ----------------------------------------------------------------------------
// note_event_window_scheduler
// Note table with block-window event collection and sorted event output.
// ----------------------------------------------------------------------------
// Loads and clears may arrive back to back. A query walks the note table
// through the memory's single read port, taking each loaded note through
// read, multiply, add, compare, note-on insert and note-off insert steps,
// then emits one beat per collected event, or one empty beat, at up to one
// per cycle unless ready stalls it. No command is taken during a query.
`default_nettype none

module note_event_window_scheduler #(
  parameter int unsigned MAX_NOTES  = nevs_pkg::MAX_NOTES_DEF,
  parameter int unsigned MAX_EVENTS = nevs_pkg::MAX_EVENTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        samples_per_tick_we,
  input  wire logic [31:0] samples_per_tick,
  nevs_in_if.sink          note_in,
  nevs_out_if.source       event_out
);

  localparam int unsigned AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int unsigned LW = $clog2(MAX_NOTES + 1);
  localparam int unsigned CW = $clog2(MAX_EVENTS + 1);
  localparam int unsigned IW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;

  nevs_pkg::state_t state, state_next;

  logic [31:0]    spt;
  logic [LW-1:0]  loaded;
  logic [LW-1:0]  n;
  logic [47:0]    pos;
  logic [48:0]    end_pos;
  logic [63:0]    prod_on, prod_off;
  logic           carry;
  logic [47:0]    s_on;
  logic [48:0]    s_off;
  logic           hit_on, hit_off;
  logic [15:0]    off_on, off_off;
  logic [13:0]    ps;
  logic [IW-1:0]  k;

  logic              accept, mem_we, ins, clear_ev, last_note, out_load, full;
  nevs_pkg::note_t   wnote, rnote;
  nevs_pkg::event_t  key, rd_ev;
  logic [CW-1:0]     ev_count;
  logic [32:0]       sum;

  assign accept    = note_in.valid && note_in.ready;
  assign last_note = (n + LW'(1)) == loaded;
  assign out_load  = (state == nevs_pkg::S_OUT) && (!event_out.valid || event_out.ready);
  assign full      = ev_count == CW'(MAX_EVENTS);
  assign sum       = {1'b0, rnote.start_tick} + {1'b0, rnote.length_ticks};

  assign wnote.start_tick   = note_in.note_start_tick;
  assign wnote.length_ticks = note_in.note_length_ticks;
  assign wnote.pitch        = note_in.note_pitch;
  assign wnote.strength     = note_in.note_strength;

  nevs_note_mem #(.DEPTH(MAX_NOTES), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (loaded[AW-1:0]),
    .wdata (wnote),
    .raddr (n[AW-1:0]),
    .rdata (rnote)
  );

  nevs_sorter #(.N(MAX_EVENTS), .CW(CW), .IW(IW)) u_sort (
    .clk     (clk),
    .rst     (rst),
    .clear   (clear_ev),
    .ins     (ins),
    .key     (key),
    .rd_idx  (k),
    .rd_data (rd_ev),
    .count   (ev_count)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      nevs_pkg::S_IDLE: begin
        if (accept && (note_in.operation == nevs_pkg::OP_QUERY)) begin
          state_next = (loaded == '0) ? nevs_pkg::S_OUT : nevs_pkg::S_RD;
        end
      end
      nevs_pkg::S_RD:  state_next = nevs_pkg::S_MUL;
      nevs_pkg::S_MUL: state_next = nevs_pkg::S_ADD;
      nevs_pkg::S_ADD: state_next = nevs_pkg::S_CMP;
      nevs_pkg::S_CMP: state_next = nevs_pkg::S_ON;
      nevs_pkg::S_ON:  state_next = nevs_pkg::S_OFF;
      nevs_pkg::S_OFF: state_next = last_note ? nevs_pkg::S_OUT : nevs_pkg::S_RD;
      nevs_pkg::S_OUT: begin
        if (out_load && ((ev_count == '0) || ((CW'(k) + CW'(1)) == ev_count))) begin
          state_next = nevs_pkg::S_IDLE;
        end
      end
      default: state_next = nevs_pkg::S_IDLE;
    endcase
  end

  // Control outputs. In the idle state ready is high, so a valid beat is
  // accepted.
  always_comb begin
    note_in.ready = 1'b0;
    mem_we        = 1'b0;
    clear_ev      = 1'b0;
    ins           = 1'b0;
    key.pitch     = ps[6:0];
    key.strength  = ps[13:7];
    key.is_on     = 1'b1;
    key.offset    = off_on;
    case (state)
      nevs_pkg::S_IDLE: begin
        note_in.ready = 1'b1;
        mem_we   = note_in.valid && (note_in.operation == nevs_pkg::OP_LOAD)
                   && (loaded < LW'(MAX_NOTES));
        clear_ev = note_in.valid && (note_in.operation == nevs_pkg::OP_QUERY);
      end
      nevs_pkg::S_ON: begin
        ins = hit_on && !full;
      end
      nevs_pkg::S_OFF: begin
        ins        = hit_off && !full;
        key.is_on  = 1'b0;
        key.offset = off_off;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= nevs_pkg::S_IDLE;
      spt    <= nevs_pkg::SPT_RESET;
      loaded <= '0;
    end else begin
      state <= state_next;
      if (samples_per_tick_we) begin
        spt <= samples_per_tick;
      end
      if (accept) begin
        case (note_in.operation)
          nevs_pkg::OP_LOAD: begin
            if (mem_we) begin
              loaded <= loaded + LW'(1);
            end
          end
          nevs_pkg::OP_CLEAR: loaded <= '0;
          default: ;
        endcase
      end
    end
  end

  // Datapath along the table walk.
  always_ff @(posedge clk) begin
    case (state)
      nevs_pkg::S_IDLE: begin
        n       <= '0;
        k       <= '0;
        pos     <= note_in.block_pos;
        end_pos <= {1'b0, note_in.block_pos} + 49'(note_in.block_frames);
      end
      nevs_pkg::S_MUL: begin
        prod_on  <= 64'(rnote.start_tick) * 64'(spt);
        prod_off <= 64'(sum[31:0]) * 64'(spt);
        carry    <= sum[32];
        ps       <= {rnote.strength, rnote.pitch};
      end
      nevs_pkg::S_ADD: begin
        s_on  <= prod_on[63:16];
        s_off <= {1'b0, prod_off[63:16]} + (carry ? {1'b0, spt, 16'h0000} : 49'd0);
      end
      nevs_pkg::S_CMP: begin
        hit_on  <= (s_on >= pos) && ({1'b0, s_on} < end_pos);
        hit_off <= (s_off >= {1'b0, pos}) && (s_off < end_pos);
        off_on  <= s_on[15:0] - pos[15:0];
        off_off <= s_off[15:0] - pos[15:0];
      end
      nevs_pkg::S_OFF: begin
        n <= n + LW'(1);
      end
      nevs_pkg::S_OUT: begin
        if (out_load) begin
          k <= k + IW'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      event_out.valid <= 1'b0;
    end else if (out_load) begin
      event_out.valid <= 1'b1;
    end else if (event_out.ready) begin
      event_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (ev_count == '0) begin
        event_out.event_valid    <= 1'b0;
        event_out.event_offset   <= '0;
        event_out.event_is_on    <= 1'b0;
        event_out.event_pitch    <= '0;
        event_out.event_strength <= '0;
        event_out.event_last     <= 1'b1;
      end else begin
        event_out.event_valid    <= 1'b1;
        event_out.event_offset   <= rd_ev.offset;
        event_out.event_is_on    <= rd_ev.is_on;
        event_out.event_pitch    <= rd_ev.pitch;
        event_out.event_strength <= rd_ev.strength;
        event_out.event_last     <= (CW'(k) + CW'(1)) == ev_count;
      end
    end
  end

  a_loaded_bound: assert property (@(posedge clk) disable iff (rst)
    loaded <= LW'(MAX_NOTES))
    else $error("note count exceeds table depth");

  a_event_bound: assert property (@(posedge clk) disable iff (rst)
    ev_count <= CW'(MAX_EVENTS))
    else $error("event count exceeds buffer depth");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    event_out.valid && !event_out.event_valid |-> event_out.event_last)
    else $error("empty result without last mark");

  a_ins_walk: assert property (@(posedge clk) disable iff (rst)
    ins |-> (state == nevs_pkg::S_ON || state == nevs_pkg::S_OFF))
    else $error("event inserted outside the table walk");

endmodule

`default_nettype wire
